### hw/rtl/ccx_pkg.sv
// Shared types, constants and CRC-32 functions for the CRC-chained XOR cipher
`default_nettype none

package ccx_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned BYTES_W     = 4;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [WORD_W-1:0]  KEY_RESET  = 32'd12345678;
  localparam logic [WORD_W-1:0]  CRC_POLY   = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0]  CRC_ONES   = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_FULL = 3'd4;

  typedef enum logic {
    REG_INITIAL_KEY = 1'b0,
    REG_DIRECTION   = 1'b1
  } ccx_reg_t;

  typedef enum logic {
    DIR_ENCRYPT = 1'b0,
    DIR_DECRYPT = 1'b1
  } ccx_dir_t;

  typedef struct packed {
    logic [WORD_W-1:0] initial_key;
    ccx_dir_t          direction;
  } ccx_cfg_t;

  // classified word: data already masked to its valid bytes
  typedef struct packed {
    logic [WORD_W-1:0]  data;
    logic [BYTES_W-1:0] byte_en;
    logic [COUNT_W-1:0] count;
    logic               last;
  } ccx_item_t;

  typedef logic [WORD_W-1:0][WORD_W-1:0] crc_mat_t;

  // 32 bit-steps of the reflected register; elaboration use only
  function automatic logic [WORD_W-1:0] crc_shift32(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] c;
    c = v;
    for (int k = 0; k < WORD_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic crc_mat_t crc_matrix();
    crc_mat_t m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = crc_shift32(WORD_W'(1) << i);
    end
    return m;
  endfunction

  localparam crc_mat_t          CRC_MAT   = crc_matrix();
  localparam logic [WORD_W-1:0] CRC_CONST = ~crc_shift32(CRC_ONES);

  // CRC-32 of four bytes as one linear XOR network plus a constant
  function automatic logic [WORD_W-1:0] crc32_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] c;
    c = CRC_CONST;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) begin
        c = c ^ CRC_MAT[i];
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ccx_cfg.sv
// APB-style register file: initial key and direction
`default_nettype none

module ccx_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ccx_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output ccx_pkg::ccx_cfg_t               cfg
);
  import ccx_pkg::*;

  logic [WORD_W-1:0] key_r, key_nxt;
  ccx_dir_t          dir_r, dir_nxt;
  ccx_reg_t          reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = ccx_reg_t'(paddr[ADDR_W-1]);

  always_comb begin
    key_nxt = key_r;
    dir_nxt = dir_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_INITIAL_KEY: key_nxt = pwdata;
        REG_DIRECTION:   dir_nxt = ccx_dir_t'(pwdata[0]);
        default:         key_nxt = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= KEY_RESET;
      dir_r <= DIR_ENCRYPT;
    end else begin
      key_r <= key_nxt;
      dir_r <= dir_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_INITIAL_KEY: prdata = key_r;
      REG_DIRECTION:   prdata = {31'b0, dir_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.initial_key = key_r;
  assign cfg.direction   = dir_r;

endmodule

`default_nettype wire

### hw/rtl/ccx_front.sv
// Front end: takes input transfers, normalises the byte count and masks the word
`default_nettype none

module ccx_front (
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ccx_pkg::WORD_W-1:0]  in_data_word,
  input  wire logic [ccx_pkg::COUNT_W-1:0] in_byte_count,
  input  wire logic                        in_last_word,
  output logic                             push,
  output ccx_pkg::ccx_item_t               push_item,
  input  wire logic                        q_full
);
  import ccx_pkg::*;

  logic [COUNT_W-1:0] count;
  logic [BYTES_W-1:0] byte_en;
  logic [WORD_W-1:0]  mask;

  // zero or above four means a full word
  always_comb begin
    if ((in_byte_count == '0) || (in_byte_count > COUNT_FULL)) begin
      count = COUNT_FULL;
    end else begin
      count = in_byte_count;
    end
  end

  always_comb begin
    for (int b = 0; b < BYTES_W; b++) begin
      byte_en[b]      = (COUNT_W'(b) < count);
      mask[8*b +: 8]  = {8{byte_en[b]}};
    end
  end

  assign in_ready          = ~q_full;
  assign push              = in_valid & ~q_full;
  assign push_item.data    = in_data_word & mask;
  assign push_item.byte_en = byte_en;
  assign push_item.count   = count;
  assign push_item.last    = in_last_word;

endmodule

`default_nettype wire

### hw/rtl/ccx_queue.sv
// Short queue of classified words between front and back end
`default_nettype none

module ccx_queue #(
  parameter int unsigned DEPTH = ccx_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire ccx_pkg::ccx_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    q_valid,
  output ccx_pkg::ccx_item_t      q_item
);
  import ccx_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ccx_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ccx_back.sv
// Back end: key chain, XOR with the running key and the output register
`default_nettype none

module ccx_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ccx_pkg::ccx_cfg_t           cfg,
  input  wire logic                        q_valid,
  input  wire ccx_pkg::ccx_item_t          q_item,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [ccx_pkg::WORD_W-1:0]       out_result_word,
  output logic [ccx_pkg::COUNT_W-1:0]      out_result_count,
  output logic                             out_result_last
);
  import ccx_pkg::*;

  logic [WORD_W-1:0]  key_r, key_nxt;
  logic               start_r, start_nxt;
  logic               valid_r, valid_nxt;
  logic [WORD_W-1:0]  word_r;
  logic [COUNT_W-1:0] count_r;
  logic               last_r;

  logic [WORD_W-1:0]  mask;
  logic [WORD_W-1:0]  key;
  logic [WORD_W-1:0]  res;
  logic [WORD_W-1:0]  cipher;

  always_comb begin
    for (int b = 0; b < BYTES_W; b++) begin
      mask[8*b +: 8] = {8{q_item.byte_en[b]}};
    end
  end

  assign pop    = q_valid & (~valid_r | out_ready);
  assign key    = start_r ? cfg.initial_key : key_r;
  assign res    = (q_item.data ^ key) & mask;
  assign cipher = (cfg.direction == DIR_DECRYPT) ? q_item.data : res;

  always_comb begin
    key_nxt   = key_r;
    start_nxt = start_r;
    valid_nxt = valid_r;
    if (pop) begin
      key_nxt   = crc32_word(cipher);
      start_nxt = q_item.last;
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= KEY_RESET;
      start_r <= 1'b1;
      valid_r <= 1'b0;
    end else begin
      key_r   <= key_nxt;
      start_r <= start_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word_r  <= res;
      count_r <= q_item.count;
      last_r  <= q_item.last;
    end
  end

  assign out_valid        = valid_r;
  assign out_result_word  = word_r;
  assign out_result_count = count_r;
  assign out_result_last  = last_r;

endmodule

`default_nettype wire

### hw/rtl/crc_chained_xor_cipher_top.sv
// CRC-chained XOR cipher: top level joining register file, front end, queue and back end
//
// Input channel (in_*): one 32-bit word per transfer, byte 0 in bits 7:0, with
// the number of valid bytes (0 or above 4 counts as 4) and an end-of-message flag.
// Output channel (out_*): one result word per input word, invalid bytes zero.
// Registers via the APB-style port: initial key at 0x0, direction at 0x4
// (0 encrypt, 1 decrypt); write them only while no word is in flight.
// Path: a result passes from its input transfer through a queue slot, then the
// output register; the pop from the queue waits while the output register holds
// a result not yet taken. Throughput: one word per cycle while the receiver keeps
// out_ready high; the rate is set by the key loop in the back end, a combinational
// CRC-32 XOR network into the key register.
// Reset: registers return to key 12345678 and encrypt, the queue empties and
// the next word starts a message.
// Receiver stall: the output register holds its result, the queue behind it
// fills (QUEUE_DEPTH words) and in_ready then drops until the receiver takes.
`default_nettype none

module crc_chained_xor_cipher_top #(
  parameter int unsigned QUEUE_DEPTH = ccx_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ccx_pkg::WORD_W-1:0]  in_data_word,
  input  wire logic [ccx_pkg::COUNT_W-1:0] in_byte_count,
  input  wire logic                        in_last_word,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [ccx_pkg::WORD_W-1:0]       out_result_word,
  output logic [ccx_pkg::COUNT_W-1:0]      out_result_count,
  output logic                             out_result_last,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ccx_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import ccx_pkg::*;

  ccx_cfg_t  cfg;
  ccx_item_t push_item;
  ccx_item_t q_item;
  logic      push;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;

  ccx_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccx_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last_word  (in_last_word),
    .push          (push),
    .push_item     (push_item),
    .q_full        (q_full)
  );

  ccx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  ccx_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_word  (out_result_word),
    .out_result_count (out_result_count),
    .out_result_last  (out_result_last)
  );

  a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> q_valid)
    else $error("queue empty after an input transfer");

  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop))
    else $error("result presented without a queue pop");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_count == 3'd1 || out_result_count == 3'd2 ||
                   out_result_count == 3'd3 || out_result_count == 3'd4))
    else $error("result byte count out of range");

  a_pad_bytes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_count == 3'd1) |-> (out_result_word[31:8] == 24'd0))
    else $error("padding bytes not zero in a one-byte result");

endmodule

`default_nettype wire

### tb/tb_crc_chained_xor_cipher_top.sv
// Self-checking testbench for the CRC-chained XOR cipher top level
`default_nettype none

module tb_crc_chained_xor_cipher_top;
  import ccx_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_WORDS  = 220;

  typedef struct {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
    logic               last;
  } cipher_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [WORD_W-1:0]    in_data_word = '0;
  logic [COUNT_W-1:0]   in_byte_count = COUNT_FULL;
  logic                 in_last_word = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_W-1:0]    out_result_word;
  logic [COUNT_W-1:0]   out_result_count;
  logic                 out_result_last;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // predictor state
  logic [WORD_W-1:0]    cfg_key = KEY_RESET;
  ccx_dir_t             cfg_dir = DIR_ENCRYPT;
  logic [WORD_W-1:0]    key_chain = KEY_RESET;
  logic                 at_msg_start = 1'b1;

  cipher_result_t       pending_results[$];
  int unsigned          err_count = 0;
  int unsigned          n_words = 0;
  int unsigned          n_msgs = 0;
  int unsigned          n_partial = 0;
  int unsigned          n_odd_count = 0;
  int unsigned          n_decrypt = 0;
  int unsigned          n_checked = 0;
  int unsigned          n_cfg_writes = 0;
  bit                   src_steady = 1'b0;
  bit                   sink_steady = 1'b0;
  int unsigned          stall_left = 0;
  int unsigned          sink_pick;

  crc_chained_xor_cipher_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_word     (in_data_word),
    .in_byte_count    (in_byte_count),
    .in_last_word     (in_last_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_word  (out_result_word),
    .out_result_count (out_result_count),
    .out_result_last  (out_result_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] crc_of_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] c;
    c = '1;
    for (int b = 0; b < 4; b++) begin
      c = c ^ {24'h0, w[8*b +: 8]};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return ~c;
  endfunction

  // advances the key chain; one result per word
  function automatic cipher_result_t cipher_predict(input logic [WORD_W-1:0] data,
                                                    input logic [COUNT_W-1:0] count,
                                                    input logic last);
    int unsigned       nbytes;
    logic [WORD_W-1:0] keep;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] crc_in;
    cipher_result_t    r;
    nbytes = (count == 0 || count > COUNT_FULL) ? 4 : count;
    keep = '0;
    for (int b = 0; b < 4; b++) begin
      if (b < nbytes) keep[8*b +: 8] = 8'hFF;
    end
    key = at_msg_start ? cfg_key : key_chain;
    r.word = (data ^ key) & keep;
    r.count = COUNT_W'(nbytes);
    r.last = last;
    crc_in = (cfg_dir == DIR_DECRYPT) ? (data & keep) : r.word;
    key_chain = crc_of_word(crc_in);
    at_msg_start = last;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (src_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] data, input logic [COUNT_W-1:0] count,
                           input logic last);
    int unsigned    gap;
    cipher_result_t exp_res;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= data;
    in_byte_count <= count;
    in_last_word  <= last;
    do @(posedge clk); while (!in_ready);
    if (cfg_dir == DIR_DECRYPT) n_decrypt++;
    exp_res = cipher_predict(data, count, last);
    pending_results.insert(pending_results.size(), exp_res);
    n_words++;
    if (last) n_msgs++;
    if (count == 0 || count > COUNT_FULL) n_odd_count++;
    else if (count < COUNT_FULL) n_partial++;
  endtask

  // sender stops until every result is back and the pipeline is empty
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input ccx_reg_t idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input ccx_reg_t idx, input logic [31:0] value);
    logic [31:0] rd;
    wait_for_drain();
    apb_xfer(1'b1, idx, value, rd);
    n_cfg_writes++;
    case (idx)
      REG_INITIAL_KEY: cfg_key = value;
      REG_DIRECTION:   cfg_dir = ccx_dir_t'(value[0]);
      default: ;
    endcase
    apb_xfer(1'b0, idx, '0, rd);
    if ((idx == REG_INITIAL_KEY && rd !== value) ||
        (idx == REG_DIRECTION && rd[0] !== value[0])) begin
      $display("%0t: register %s readback mismatch: expected %h, got %h",
               $time, idx.name(), value, rd);
      err_count++;
    end
  endtask

  task automatic test_reset_state();
    send_word(32'h0000_0000, 3'd4, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
    send_word(32'hA5A5_A5A5, 3'd3, 1'b0);
    send_word(32'h1234_5678, 3'd0, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    send_word(32'h0000_0000, 3'd1, 1'b1);
    send_word(32'hDEAD_BEEF, 3'd2, 1'b1);
  endtask

  task automatic test_decrypt_key_extremes();
    write_reg(REG_INITIAL_KEY, 32'h0000_0000);
    write_reg(REG_DIRECTION, {31'b0, DIR_DECRYPT});
    send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
    send_word(32'h0000_0000, 3'd4, 1'b0);
    send_word(32'h5A5A_5A5A, 3'd5, 1'b0);
    send_word(32'hC3C3_C3C3, 3'd1, 1'b1);
    write_reg(REG_INITIAL_KEY, 32'hFFFF_FFFF);
    send_word(32'h0000_0000, 3'd4, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd3, 1'b1);
  endtask

  // direction switches on the next word, key only at the next message
  task automatic test_config_mid_message();
    write_reg(REG_DIRECTION, {31'b0, DIR_ENCRYPT});
    write_reg(REG_INITIAL_KEY, 32'h0F1E_2D3C);
    send_word(32'h1122_3344, 3'd4, 1'b0);
    send_word(32'h5566_7788, 3'd4, 1'b0);
    write_reg(REG_DIRECTION, {31'b0, DIR_DECRYPT});
    write_reg(REG_INITIAL_KEY, 32'hCAFE_F00D);
    send_word(32'h99AA_BBCC, 3'd4, 1'b0);
    send_word(32'hDDEE_FF00, 3'd2, 1'b1);
    send_word(32'h0102_0304, 3'd4, 1'b1);
  endtask

  task automatic run_traffic(input int unsigned target);
    int unsigned start_count;
    int unsigned pick;
    int unsigned len;
    start_count = n_words;
    while (n_words - start_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (int i = 1; i < len; i++) send_word(rand_word(), COUNT_FULL, 1'b0);
        send_word(rand_word(),
                  ($urandom_range(0, 1) != 0) ? COUNT_FULL : COUNT_W'($urandom_range(1, 3)),
                  1'b1);
      end else if (pick < 90) begin
        send_word(rand_word(), COUNT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else begin
        // broken message: random counts 0 to 7 inside, no closing word
        len = $urandom_range(2, 6);
        for (int i = 0; i < len; i++) begin
          send_word(rand_word(), COUNT_W'($urandom_range(0, 7)), 1'b0);
        end
      end
    end
  endtask

  task automatic test_random_phases();
    logic [WORD_W-1:0] key_set[6];
    ccx_dir_t          dir;
    key_set = '{$urandom(), 32'h0000_0000, 32'hFFFF_FFFF, $urandom(), $urandom(), KEY_RESET};
    for (int phase = 0; phase < 6; phase++) begin
      dir = (phase == 4) ? ccx_dir_t'($urandom_range(0, 1)) : ccx_dir_t'(phase % 2);
      write_reg(REG_INITIAL_KEY, key_set[phase]);
      write_reg(REG_DIRECTION, {31'b0, dir});
      src_steady  = (phase == 2);
      sink_steady = (phase == 2);
      if (phase == 3) begin
        run_traffic(PHASE_WORDS / 2);
        wait_for_drain();
        run_traffic(PHASE_WORDS / 2);
      end else begin
        run_traffic(PHASE_WORDS);
      end
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (sink_steady) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      sink_pick = $urandom_range(0, 99);
      out_ready <= 1'b1;
      if (sink_pick < 20) stall_left <= $urandom_range(1, 3);
      else if (sink_pick < 23) stall_left <= $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    cipher_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected: got word %h count %0d last %b",
                 $time, out_result_word, out_result_count, out_result_last);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_result_word !== want.word) begin
          $display("%0t: result_word mismatch: expected %h, got %h",
                   $time, want.word, out_result_word);
          err_count++;
        end
        if (out_result_count !== want.count) begin
          $display("%0t: result_count mismatch: expected %0d, got %0d",
                   $time, want.count, out_result_count);
          err_count++;
        end
        if (out_result_last !== want.last) begin
          $display("%0t: result_last mismatch: expected %b, got %b",
                   $time, want.last, out_result_last);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_decrypt_key_extremes();
    test_config_mid_message();
    test_random_phases();
    wait_for_drain();
    $display("Covered %0d words in %0d messages: %0d partial, %0d out-of-range counts,",
             n_words, n_msgs, n_partial, n_odd_count);
    $display("%0d decrypted, %0d register writes, %0d results checked",
             n_decrypt, n_cfg_writes, n_checked);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
